// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants of the sorted priority queue
// depends on nothing; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ITEM_W = 16;
	localparam int PRIO_W = 16;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef logic        [ITEM_W-1:0] item_t;
	typedef logic signed [PRIO_W-1:0] prio_t;
	typedef logic        [CNT_W-1:0]  cnt_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic  enq;
		logic  deq;
		item_t new_item;
		prio_t new_prio;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// spq_if: valid/ready channels for request and response beats
// depends on spq_pkg for field types
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if
	import spq_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  kind;
	item_t item;
	prio_t priority_req;

	modport source (output valid, output kind, output item, output priority_req, input ready);
	modport sink   (input valid, input kind, input item, input priority_req, output ready);
endinterface

interface spq_out_if
	import spq_pkg::*;
();
	logic    valid;
	logic    ready;
	status_t status;
	item_t   out_item;
	prio_t   out_priority;
	logic    head_valid;
	item_t   head_item;
	cnt_t    count;

	modport source (output valid, output status, output out_item, output out_priority,
		output head_valid, output head_item, output count, input ready);
	modport sink   (input valid, input status, input out_item, input out_priority,
		input head_valid, input head_item, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, compares the incoming priority
// with its own and shifts toward the tail on insert or toward the head on removal; uses spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic  clk,
	input  wire ctl_t  ctl,
	input  wire logic  is_head,
	input  wire logic  occ,
	input  wire logic  left_take,
	input  wire item_t left_item,
	input  wire prio_t left_prio,
	input  wire item_t right_item,
	input  wire prio_t right_prio,
	output logic       take,
	output item_t      item,
	output prio_t      prio
);

	item_t item_q;
	prio_t prio_q;
	logic  cmp;

	// head only yields to a strictly larger priority, later slots also to an equal one
	always_comb begin
		if (is_head) begin
			cmp = ctl.new_prio > prio_q;
		end else begin
			cmp = prio_q <= ctl.new_prio;
		end
		take = !occ || cmp;
	end

	always_ff @(posedge clk) begin
		if (ctl.enq && take) begin
			if (left_take) begin
				item_q <= left_item;
				prio_q <= left_prio;
			end else begin
				item_q <= ctl.new_item;
				prio_q <= ctl.new_prio;
			end
		end else if (ctl.deq) begin
			item_q <= right_item;
			prio_q <= right_prio;
		end
	end

	assign item = item_q;
	assign prio = prio_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_core.sv =====
// sorted_priority_queue_core: top level, a chain of spq_cell slots plus fill count and result register
// depends on spq_pkg, spq_if and spq_cell
`timescale 1ns / 1ps
`default_nettype none

// Max-priority queue of DEPTH entries kept sorted in a row of cells, head in cell 0.
// Each request beat either inserts an (item, priority) pair or removes the head; every
// cell compares its own priority with the incoming one in parallel, so an insert or a
// removal needs no search pass. The response beat appears in the cycle after the
// request and sits in an output register; one request is taken per cycle whenever that
// register is empty or its beat is taken in the same cycle. Inserting into a full queue
// drops the entry with overflow status, removing from an empty queue reports underflow.
// No clearing pass is needed after reset.

module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	cnt_t    count_q;
	logic    rsp_valid_q;
	status_t status_q;
	item_t   out_item_q;
	prio_t   out_prio_q;
	logic    head_valid_q;
	item_t   head_item_q;
	cnt_t    rsp_count_q;

	logic    accept;
	logic    is_deq;
	logic    full;
	logic    empty;
	ctl_t    ctl;

	logic  [DEPTH-1:0] occ;
	logic  [DEPTH-1:0] take;
	item_t             cell_item [DEPTH];
	prio_t             cell_prio [DEPTH];

	status_t status_nxt;
	item_t   out_item_nxt;
	prio_t   out_prio_nxt;
	item_t   head_item_nxt;
	cnt_t    count_nxt;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_deq    = (req.kind == KIND_DEQ);
	assign full      = (count_q == cnt_t'(DEPTH));
	assign empty     = (count_q == '0);

	assign ctl.enq      = accept && !is_deq && !full;
	assign ctl.deq      = accept && is_deq && !empty;
	assign ctl.new_item = req.item;
	assign ctl.new_prio = req.priority_req;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = count_q > cnt_t'(i);

		if (i == 0) begin : g_first
			spq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.is_head    (1'b1),
				.occ        (occ[i]),
				.left_take  (1'b0),
				.left_item  (req.item),
				.left_prio  (req.priority_req),
				.right_item (cell_item[i+1]),
				.right_prio (cell_prio[i+1]),
				.take       (take[i]),
				.item       (cell_item[i]),
				.prio       (cell_prio[i])
			);
		end else if (i == DEPTH - 1) begin : g_last
			spq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.is_head    (1'b0),
				.occ        (occ[i]),
				.left_take  (take[i-1]),
				.left_item  (cell_item[i-1]),
				.left_prio  (cell_prio[i-1]),
				.right_item (cell_item[i]),
				.right_prio (cell_prio[i]),
				.take       (take[i]),
				.item       (cell_item[i]),
				.prio       (cell_prio[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.is_head    (1'b0),
				.occ        (occ[i]),
				.left_take  (take[i-1]),
				.left_item  (cell_item[i-1]),
				.left_prio  (cell_prio[i-1]),
				.right_item (cell_item[i+1]),
				.right_prio (cell_prio[i+1]),
				.take       (take[i]),
				.item       (cell_item[i]),
				.prio       (cell_prio[i])
			);
		end
	end

	always_comb begin
		status_nxt    = ST_OK;
		out_item_nxt  = '0;
		out_prio_nxt  = '0;
		count_nxt     = count_q;
		head_item_nxt = empty ? '0 : cell_item[0];
		if (is_deq) begin
			if (empty) begin
				status_nxt = ST_UNDERFLOW;
			end else begin
				out_item_nxt  = cell_item[0];
				out_prio_nxt  = cell_prio[0];
				count_nxt     = count_q - cnt_t'(1);
				head_item_nxt = (count_q > cnt_t'(1)) ? cell_item[1] : '0;
			end
		end else begin
			if (full) begin
				status_nxt = ST_OVERFLOW;
			end else begin
				count_nxt     = count_q + cnt_t'(1);
				head_item_nxt = take[0] ? req.item : cell_item[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_nxt;
			out_item_q   <= out_item_nxt;
			out_prio_q   <= out_prio_nxt;
			head_valid_q <= (count_nxt != '0);
			head_item_q  <= head_item_nxt;
			rsp_count_q  <= count_nxt;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_item     = out_item_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.head_valid   = head_valid_q;
	assign rsp.head_item    = head_item_q;
	assign rsp.count        = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("fill count beyond depth");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.deq |=> count_q == $past(count_q) - cnt_t'(1))
		else $error("removal did not drop the fill count by one");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_OVERFLOW |-> rsp_count_q == cnt_t'(DEPTH))
		else $error("overflow reported on a queue that is not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_UNDERFLOW |-> !head_valid_q && rsp_count_q == '0)
		else $error("underflow reported on a queue that is not empty");

endmodule

`default_nettype wire
